### rtl/core/bpfa_pkg.sv
// Package for the bin packing fit allocator: word types, status and mode
// codes, register indexes and the cell control structs. No dependencies.
package bpfa_pkg;

   localparam int SIZE_W     = 16;
   localparam int OPEN_W     = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [SIZE_W-1:0] CAP_RESET = SIZE_W'(100);

   typedef enum logic [1:0] {
      ST_PLACED = 2'd0,
      ST_NEW    = 2'd1,
      ST_REJECT = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   localparam logic [1:0] MODE_BEST  = 2'd0;
   localparam logic [1:0] MODE_WORST = 2'd1;
   localparam logic [1:0] MODE_NEXT  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_BIN_CAPACITY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIT_MODE     = 1'd1;

   typedef struct packed {
      logic              new_run;
      logic [SIZE_W-1:0] item_size;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [SIZE_W-1:0] residual_before;
      logic [SIZE_W-1:0] residual_after;
      logic [SIZE_W-1:0] bins_used;
      logic [OPEN_W-1:0] open_bins;
   } rsp_type;

   // search broadcast, used in the accept cycle
   typedef struct packed {
      logic              capture;
      logic              worst;
      logic [SIZE_W-1:0] item;
   } srch_type;

   // update broadcast, used in the update cycle
   typedef struct packed {
      logic              en;
      logic              remove;
      logic              insert;
      logic [SIZE_W-1:0] value;
   } upd_type;

endpackage

### rtl/core/bpfa_cell.sv
// One slot of the sorted residual chain: holds a residual, compares it
// against the broadcast words and shifts with its neighbors. Uses bpfa_pkg.
module bpfa_cell #(
   parameter int IDX = 0,
   parameter int CW  = 7
) (
   input  logic                       clock,
   input  logic [CW-1:0]              count,
   input  bpfa_pkg::srch_type         srch,
   input  bpfa_pkg::upd_type          upd,
   input  logic [bpfa_pkg::SIZE_W-1:0] left_val,
   input  logic [bpfa_pkg::SIZE_W-1:0] right_val,
   input  logic                       left_ge,
   input  logic                       left_le,
   input  logic                       left_rm,
   output logic [bpfa_pkg::SIZE_W-1:0] val,
   output logic                       ge,
   output logic                       le,
   output logic                       rm,
   output logic                       hit
);

   localparam logic [CW-1:0] IDX_C = CW'(IDX);

   logic [bpfa_pkg::SIZE_W-1:0] val_ff, val_in;
   logic                        rm_ff;
   logic                        slot_valid;
   logic                        at_pos;
   logic                        past_pos;

   assign slot_valid = IDX_C < count;
   assign ge  = slot_valid && (val_ff >= srch.item);
   // sorted ascending: best fit is the first ge slot, worst fit the last slot
   assign hit = srch.worst ? (ge && (IDX_C == count - CW'(1))) : (ge && !left_ge);
   assign le  = slot_valid && (val_ff <= upd.value);
   assign at_pos   = !le && left_le;
   assign past_pos = !le && !left_le;
   assign val = val_ff;
   assign rm  = rm_ff;

   always_comb begin
      val_in = val_ff;
      if (upd.en) begin
         if (upd.remove && !upd.insert) begin
            if (rm_ff) val_in = right_val;
         end else if (upd.insert) begin
            if (at_pos) begin
               val_in = upd.value;
            end else if (past_pos && !(upd.remove && left_rm)) begin
               val_in = left_val;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      // rm marks the removed slot and, for best fit, every slot after it
      if (srch.capture) rm_ff <= srch.worst ? hit : ge;
   end

endmodule

### rtl/core/bin_packing_fit_allocator.sv
// Top level of the bin packing fit allocator: handshakes, registers,
// counters and the chain of bpfa_cell slots. Uses bpfa_pkg and bpfa_cell.
//
//   channel  ports                          direction  word
//   req      req_valid req_ready req_data   in         req_type
//   rsp      rsp_valid rsp_ready rsp_data   out        rsp_type
//   csr      csr_we csr_index csr_wdata     in         write only
//
// In the accept cycle every cell is compared against the item and the fit
// position is latched; the update cycle then rewrites the chain and loads the
// output register. The next item is taken in the cycle after that.
// A stalled rsp holds the update cycle until the output register frees.
// Reset clears counters and resets config; slots stay stale, gated by count.
module bin_packing_fit_allocator #(
   parameter int MAX_BINS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  bpfa_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output bpfa_pkg::rsp_type              rsp_data,
   input  logic                           csr_we,
   input  logic [bpfa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bpfa_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int SW = bpfa_pkg::SIZE_W;
   localparam int CW = $clog2(MAX_BINS + 1);

   logic          busy_ff;
   logic          rsp_valid_ff;
   bpfa_pkg::rsp_type rsp_ff, rsp_in;
   logic [SW-1:0] cap_ff;
   logic [1:0]    mode_ff;
   logic [SW-1:0] item_ff;
   logic          found_ff;
   logic [SW-1:0] sel_ff;
   logic [CW-1:0] open_cnt_ff, open_cnt_in;
   logic [SW-1:0] bin_cnt_ff, bin_cnt_in;
   logic [SW-1:0] cur_res_ff, cur_res_in;
   logic          cur_open_ff, cur_open_in;

   logic          accept;
   logic          upd_go;
   logic [CW-1:0] cell_count;
   logic [SW-1:0] sel_val;
   logic          found;
   bpfa_pkg::srch_type srch;
   bpfa_pkg::upd_type  upd;

   logic [SW-1:0] val_w [MAX_BINS];
   logic          ge_w  [MAX_BINS];
   logic          le_w  [MAX_BINS];
   logic          rm_w  [MAX_BINS];
   logic          hit_w [MAX_BINS];

   assign req_ready = !busy_ff && !reset;
   assign accept    = req_valid && req_ready;
   assign upd_go    = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // during accept a new run sees an empty chain
   assign cell_count = (!busy_ff && req_data.new_run) ? '0 : open_cnt_ff;

   assign srch.capture = accept;
   assign srch.worst   = (mode_ff == bpfa_pkg::MODE_WORST);
   assign srch.item    = req_data.item_size;

   for (genvar g = 0; g < MAX_BINS; g++) begin : g_cell
      logic [SW-1:0] lv, rv;
      logic          lge, lle, lrm;
      if (g == 0) begin : g_first
         assign lv  = '0;
         assign lge = 1'b0;
         assign lle = 1'b1;
         assign lrm = 1'b0;
      end else begin : g_mid
         assign lv  = val_w[g-1];
         assign lge = ge_w[g-1];
         assign lle = le_w[g-1];
         assign lrm = rm_w[g-1];
      end
      if (g == MAX_BINS - 1) begin : g_last
         assign rv = '0;
      end else begin : g_inner
         assign rv = val_w[g+1];
      end
      bpfa_cell #(
         .IDX (g),
         .CW  (CW)
      ) u_cell (
         .clock     (clock),
         .count     (cell_count),
         .srch      (srch),
         .upd       (upd),
         .left_val  (lv),
         .right_val (rv),
         .left_ge   (lge),
         .left_le   (lle),
         .left_rm   (lrm),
         .val       (val_w[g]),
         .ge        (ge_w[g]),
         .le        (le_w[g]),
         .rm        (rm_w[g]),
         .hit       (hit_w[g])
      );
   end

   // hit is one-hot or empty, so an OR picks the chosen residual
   always_comb begin
      sel_val = '0;
      found   = 1'b0;
      for (int i = 0; i < MAX_BINS; i++) begin
         sel_val = sel_val | (hit_w[i] ? val_w[i] : '0);
         found   = found | hit_w[i];
      end
   end

   always_comb begin
      logic [SW-1:0] res_before;
      logic [SW-1:0] after;
      logic          new_bin;
      res_before  = '0;
      after       = '0;
      new_bin     = 1'b0;
      upd         = '0;
      rsp_in      = rsp_ff;
      open_cnt_in = open_cnt_ff;
      bin_cnt_in  = bin_cnt_ff;
      cur_res_in  = cur_res_ff;
      cur_open_in = cur_open_ff;
      rsp_in.status = bpfa_pkg::ST_PLACED;
      if (item_ff > cap_ff) begin
         rsp_in.status = bpfa_pkg::ST_REJECT;
      end else if (mode_ff == bpfa_pkg::MODE_NEXT) begin
         if (cur_open_ff && (item_ff <= cur_res_ff)) begin
            res_before = cur_res_ff;
         end else begin
            rsp_in.status = bpfa_pkg::ST_NEW;
            res_before  = cap_ff;
            new_bin     = 1'b1;
            cur_open_in = 1'b1;
         end
         after      = res_before - item_ff;
         cur_res_in = after;
      end else if (found_ff) begin
         res_before = sel_ff;
         after      = res_before - item_ff;
         // a zero-size item leaves the chain as it is
         upd.en     = (item_ff != '0);
         upd.remove = 1'b1;
         upd.insert = (after != '0);
         upd.value  = after;
         if (after == '0) open_cnt_in = open_cnt_ff - CW'(1);
      end else begin
         rsp_in.status = bpfa_pkg::ST_NEW;
         res_before = cap_ff;
         after      = cap_ff - item_ff;
         new_bin    = 1'b1;
         upd.value  = after;
         if (after != '0) begin
            if (open_cnt_ff < CW'(MAX_BINS)) begin
               upd.en      = 1'b1;
               upd.insert  = 1'b1;
               open_cnt_in = open_cnt_ff + CW'(1);
            end else begin
               rsp_in.status = bpfa_pkg::ST_FULL;
            end
         end
      end
      if (new_bin && (bin_cnt_ff != '1)) bin_cnt_in = bin_cnt_ff + SW'(1);
      if (!upd_go) upd.en = 1'b0;
      rsp_in.residual_before = res_before;
      rsp_in.residual_after  = after;
      rsp_in.bins_used       = bin_cnt_in;
      rsp_in.open_bins       = bpfa_pkg::OPEN_W'(open_cnt_in);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff  <= req_data.item_size;
         found_ff <= found;
         sel_ff   <= sel_val;
      end
      if (upd_go) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= bpfa_pkg::CAP_RESET;
         mode_ff      <= bpfa_pkg::MODE_BEST;
         open_cnt_ff  <= '0;
         bin_cnt_ff   <= '0;
         cur_res_ff   <= '0;
         cur_open_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               bpfa_pkg::CSR_BIN_CAPACITY: cap_ff  <= csr_wdata[SW-1:0];
               bpfa_pkg::CSR_FIT_MODE:     mode_ff <= csr_wdata[1:0];
               default: ;
            endcase
         end
         if (accept) begin
            busy_ff <= 1'b1;
            if (req_data.new_run) begin
               open_cnt_ff <= '0;
               bin_cnt_ff  <= '0;
               cur_res_ff  <= '0;
               cur_open_ff <= 1'b0;
            end
         end else if (upd_go) begin
            busy_ff     <= 1'b0;
            open_cnt_ff <= open_cnt_in;
            bin_cnt_ff  <= bin_cnt_in;
            cur_res_ff  <= cur_res_in;
            cur_open_ff <= cur_open_in;
         end
         if (upd_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

### verif/tb.sv
// Self-checking testbench for bin_packing_fit_allocator: directed and random
// placement traffic checked against an in-bench fit predictor. Uses bpfa_pkg.
module tb;

   localparam int STORE_DEPTH = 64;
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int MAX_PRINTS = 100;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   bpfa_pkg::req_type               req_data;
   logic                            rsp_valid;
   logic                            rsp_ready;
   bpfa_pkg::rsp_type               rsp_data;
   logic                            csr_we;
   logic [bpfa_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [bpfa_pkg::CSR_DATA_W-1:0] csr_wdata;

   // predictor state
   logic [bpfa_pkg::SIZE_W-1:0] resid_q [0:STORE_DEPTH-1];
   int                          open_cnt;
   logic [bpfa_pkg::SIZE_W-1:0] bins_cnt;
   logic [bpfa_pkg::SIZE_W-1:0] cur_resid;
   bit                          cur_open;
   logic [bpfa_pkg::SIZE_W-1:0] cap_reg;
   logic [1:0]                  mode_reg;

   bpfa_pkg::rsp_type expected_placements [$];
   bpfa_pkg::rsp_type want;
   int      mismatches;
   int      items_sent;
   int      words_checked;
   int      config_writes;
   int      status_seen [4];
   int      idle_pct;

   bin_packing_fit_allocator #(.MAX_BINS(STORE_DEPTH)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #8000000;
      $display("Verification failed");
      $finish;
   end

   // ---------------- predictor ----------------
   function automatic void clear_run();
      open_cnt  = 0;
      bins_cnt  = '0;
      cur_resid = '0;
      cur_open  = 1'b0;
   endfunction

   function automatic void bump_bins();
      if (bins_cnt != '1)
         bins_cnt = bins_cnt + bpfa_pkg::SIZE_W'(1);
   endfunction

   function automatic void store_remove(int idx);
      int i;
      for (i = idx; i + 1 < open_cnt; i++)
         resid_q[i] = resid_q[i+1];
      open_cnt--;
   endfunction

   // returns 0 when the store is full and the residual is dropped
   function automatic bit store_insert(logic [bpfa_pkg::SIZE_W-1:0] v);
      int pos;
      int i;
      if (open_cnt >= STORE_DEPTH)
         return 1'b0;
      pos = 0;
      while (pos < open_cnt && resid_q[pos] <= v)
         pos++;
      for (i = open_cnt; i > pos; i--)
         resid_q[i] = resid_q[i-1];
      resid_q[pos] = v;
      open_cnt++;
      return 1'b1;
   endfunction

   function automatic bpfa_pkg::rsp_type place_item(bpfa_pkg::req_type w);
      bpfa_pkg::rsp_type           p;
      logic [bpfa_pkg::SIZE_W-1:0] item;
      int                          idx;
      int                          i;
      bit                          found;
      p    = '0;
      item = w.item_size;
      if (w.new_run)
         clear_run();
      if (item > cap_reg) begin
         p.status = bpfa_pkg::ST_REJECT;
      end else if (mode_reg == bpfa_pkg::MODE_NEXT) begin
         if (cur_open && item <= cur_resid) begin
            p.status          = bpfa_pkg::ST_PLACED;
            p.residual_before = cur_resid;
         end else begin
            p.status          = bpfa_pkg::ST_NEW;
            p.residual_before = cap_reg;
            bump_bins();
            cur_open = 1'b1;
         end
         p.residual_after = p.residual_before - item;
         cur_resid        = p.residual_after;
      end else begin
         found = 1'b0;
         idx   = 0;
         if (mode_reg == bpfa_pkg::MODE_WORST) begin
            if (open_cnt > 0 && resid_q[open_cnt-1] >= item) begin
               idx   = open_cnt - 1;
               found = 1'b1;
            end
         end else begin
            // best fit; the spare mode code falls here too
            for (i = 0; i < open_cnt; i++) begin
               if (!found && resid_q[i] >= item) begin
                  idx   = i;
                  found = 1'b1;
               end
            end
         end
         if (found) begin
            p.status          = bpfa_pkg::ST_PLACED;
            p.residual_before = resid_q[idx];
            p.residual_after  = resid_q[idx] - item;
            store_remove(idx);
            if (p.residual_after != '0)
               void'(store_insert(p.residual_after));
         end else begin
            p.status          = bpfa_pkg::ST_NEW;
            p.residual_before = cap_reg;
            p.residual_after  = cap_reg - item;
            bump_bins();
            if (p.residual_after != '0 && !store_insert(p.residual_after))
               p.status = bpfa_pkg::ST_FULL;
         end
      end
      p.bins_used = bins_cnt;
      p.open_bins = bpfa_pkg::OPEN_W'(open_cnt);
      return p;
   endfunction

   // ---------------- checking ----------------
   task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
      if (mismatches < MAX_PRINTS)
         $display("MISMATCH %s: got %0d, want %0d (word %0d)", what, got, exp_val,
                  words_checked);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_placements.size() == 0) begin
            flag_mismatch("unexpected rsp word", 32'(rsp_data.status), 0);
         end else begin
            want = expected_placements.pop_front();
            if (rsp_data.status != want.status)
               flag_mismatch("status", 32'(rsp_data.status), 32'(want.status));
            if (rsp_data.residual_before != want.residual_before)
               flag_mismatch("residual_before", 32'(rsp_data.residual_before),
                             32'(want.residual_before));
            if (rsp_data.residual_after != want.residual_after)
               flag_mismatch("residual_after", 32'(rsp_data.residual_after),
                             32'(want.residual_after));
            if (rsp_data.bins_used != want.bins_used)
               flag_mismatch("bins_used", 32'(rsp_data.bins_used), 32'(want.bins_used));
            if (rsp_data.open_bins != want.open_bins)
               flag_mismatch("open_bins", 32'(rsp_data.open_bins), 32'(want.open_bins));
            status_seen[want.status]++;
         end
         words_checked++;
      end
   end

   // ---------------- driving ----------------
   always @(negedge clock)
      rsp_ready = ($urandom_range(0, 99) >= idle_pct);

   task automatic push_item(bit run, logic [bpfa_pkg::SIZE_W-1:0] size);
      bpfa_pkg::req_type w;
      w.new_run   = run;
      w.item_size = size;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = w;
      do @(posedge clock); while (!req_ready);
      expected_placements.insert(expected_placements.size(), place_item(w));
      items_sent++;
      @(negedge clock);
   endtask

   // every word yields a result, so an empty queue means the block is idle
   task automatic drain();
      int n;
      n = 0;
      req_valid = 1'b0;
      while (expected_placements.size() != 0 && n < 20000) begin
         @(negedge clock);
         n++;
      end
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(logic [bpfa_pkg::CSR_IDX_W-1:0] idx,
                            logic [bpfa_pkg::CSR_DATA_W-1:0] val);
      drain();
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == bpfa_pkg::CSR_BIN_CAPACITY)
         cap_reg = val;
      else
         mode_reg = val[1:0];
      config_writes++;
   endtask

   function automatic logic [bpfa_pkg::SIZE_W-1:0] pick_size(bit big);
      int unsigned c;
      int unsigned r;
      c = 32'(cap_reg);
      r = $urandom_range(0, 99);
      if (r < 5)
         return bpfa_pkg::SIZE_W'($urandom_range(0, 65535));
      if (r < 10 && c < 65535)
         return bpfa_pkg::SIZE_W'($urandom_range(c + 1, 65535));
      if (r < 13)
         return '0;
      if (r < 19)
         return bpfa_pkg::SIZE_W'(c);
      // big items never share a bin, so the store fills up
      if (big || r < 50)
         return bpfa_pkg::SIZE_W'($urandom_range(c / 2 + 1, c));
      return bpfa_pkg::SIZE_W'($urandom_range(1, (c >= 6) ? c / 3 : 1));
   endfunction

   // ---------------- tests ----------------
   task automatic test_best_fit();
      write_csr(bpfa_pkg::CSR_FIT_MODE, {14'd0, bpfa_pkg::MODE_BEST});
      push_item(1'b0, 16'd0);
      push_item(1'b0, 16'd100);
      push_item(1'b0, 16'd101);
      push_item(1'b0, 16'hFFFF);
      push_item(1'b1, 16'd30);
      push_item(1'b0, 16'd50);
      push_item(1'b0, 16'd20);
   endtask

   task automatic test_worst_fit();
      write_csr(bpfa_pkg::CSR_FIT_MODE, {14'd0, bpfa_pkg::MODE_WORST});
      push_item(1'b1, 16'd60);
      push_item(1'b0, 16'd70);
      push_item(1'b0, 16'd25);
      push_item(1'b0, 16'd35);
   endtask

   task automatic test_next_fit();
      write_csr(bpfa_pkg::CSR_FIT_MODE, {14'd0, bpfa_pkg::MODE_NEXT});
      push_item(1'b1, 16'd60);
      push_item(1'b0, 16'd40);
      // current bin holds zero space yet stays open
      push_item(1'b0, 16'd0);
      push_item(1'b0, 16'd1);
   endtask

   task automatic test_edge_settings();
      write_csr(bpfa_pkg::CSR_FIT_MODE, {14'd0, MODE_SPARE});
      push_item(1'b1, 16'd10);
      push_item(1'b0, 16'd5);
      write_csr(bpfa_pkg::CSR_BIN_CAPACITY, 16'hFFFF);
      push_item(1'b1, 16'hFFFF);
      push_item(1'b0, 16'd0);
      push_item(1'b0, 16'h8000);
      write_csr(bpfa_pkg::CSR_BIN_CAPACITY, 16'd0);
      push_item(1'b1, 16'd0);
      push_item(1'b0, 16'd0);
      push_item(1'b0, 16'd1);
      write_csr(bpfa_pkg::CSR_BIN_CAPACITY, 16'd1);
      push_item(1'b0, 16'd1);
   endtask

   // capacity 1 in next fit opens a bin per word, sent back to back
   task automatic test_bin_counting();
      int k;
      idle_pct = 0;
      write_csr(bpfa_pkg::CSR_BIN_CAPACITY, 16'd1);
      write_csr(bpfa_pkg::CSR_FIT_MODE, {14'd0, bpfa_pkg::MODE_NEXT});
      push_item(1'b1, 16'd1);
      for (k = 0; k < 60; k++)
         push_item(1'b0, 16'd1);
      idle_pct = 18;
   endtask

   task automatic test_random_phases();
      int         ph;
      int         k;
      bit         big;
      logic [1:0] mode;
      for (ph = 0; ph < 13; ph++) begin
         idle_pct = (ph == 5) ? 0 : 18;
         case (ph % 6)
            0: write_csr(bpfa_pkg::CSR_BIN_CAPACITY, 16'd1);
            1: write_csr(bpfa_pkg::CSR_BIN_CAPACITY, 16'hFFFF);
            2: write_csr(bpfa_pkg::CSR_BIN_CAPACITY, 16'd100);
            3: write_csr(bpfa_pkg::CSR_BIN_CAPACITY, 16'($urandom_range(2, 20)));
            4: write_csr(bpfa_pkg::CSR_BIN_CAPACITY, 16'($urandom_range(21, 400)));
            default: write_csr(bpfa_pkg::CSR_BIN_CAPACITY, 16'($urandom_range(1, 65535)));
         endcase
         mode = (ph % 4 == 3 && $urandom_range(0, 1)) ? MODE_SPARE
                                                       : 2'($urandom_range(0, 2));
         write_csr(bpfa_pkg::CSR_FIT_MODE, {14'($urandom), mode});
         big = $urandom_range(0, 1);
         push_item(1'b1, pick_size(big));
         for (k = 1; k < 100; k++)
            push_item($urandom_range(0, 99) < 2, pick_size(big));
      end
      idle_pct = 18;
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_ready     = 1'b0;
      csr_we        = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      idle_pct      = 18;
      mismatches    = 0;
      items_sent    = 0;
      words_checked = 0;
      config_writes = 0;
      status_seen   = '{0, 0, 0, 0};
      cap_reg       = bpfa_pkg::CAP_RESET;
      mode_reg      = bpfa_pkg::MODE_BEST;
      clear_run();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_best_fit();
      test_worst_fit();
      test_next_fit();
      test_edge_settings();
      test_bin_counting();
      test_random_phases();

      drain();
      if (expected_placements.size() != 0)
         flag_mismatch("rsp words never arrived", expected_placements.size(), 0);
      $display("Run: %0d items, %0d rsp words checked, %0d register writes",
               items_sent, words_checked, config_writes);
      $display("Status mix: placed %0d, new bin %0d, rejected %0d, store full %0d",
               status_seen[bpfa_pkg::ST_PLACED], status_seen[bpfa_pkg::ST_NEW],
               status_seen[bpfa_pkg::ST_REJECT], status_seen[bpfa_pkg::ST_FULL]);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

### files.f
rtl/core/bpfa_pkg.sv
rtl/core/bpfa_cell.sv
rtl/core/bin_packing_fit_allocator.sv
verif/tb.sv
